>>> sv/les_pkg.sv
// Shared constants and codes for the link event anchor scheduler.
`timescale 1ns / 1ps
`default_nettype none
package les_pkg;

  // serial divider: dividend covers elapsed time times ppm
  localparam int DIV_N_W   = 74;
  localparam int DIV_D_W   = 22;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // serial multiplier: 64-bit operand times up to 22 bits
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 22;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam int TIME_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 22;
  localparam int IN_DATA_W = 168;
  localparam int IN_USER_W = 4;
  localparam int OUT_DATA_W = 144;

  localparam logic [16:0] JITTER_US        = 17'd40;
  localparam logic [TIME_W:0] EXPEDITE_LEAD_US = 65'd3000;
  localparam logic [17:0] CATCHUP_MARGIN_US = 18'd200;
  localparam logic [DIV_D_W-1:0] PPM_SCALE = 22'd1000000;

  // operation codes
  localparam logic [2:0] OP_ESTABLISH = 3'd0;
  localparam logic [2:0] OP_QUERY     = 3'd1;
  localparam logic [2:0] OP_ADVANCE   = 3'd2;
  localparam logic [2:0] OP_RESYNC    = 3'd3;
  localparam logic [2:0] OP_POST      = 3'd4;
  localparam logic [2:0] OP_ACK       = 3'd5;
  localparam logic [2:0] OP_EXPEDITE  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IS_INIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD     = 3'd5;

endpackage
`default_nettype wire

>>> sv/les_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module les_div import les_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DIV_N_W-1:0] dividend_i,
  input  wire logic [DIV_D_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [DIV_N_W-1:0]      quot_o,
  output logic [DIV_D_W-1:0]      rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N_W-1:0]   dq_q;
  logic [DIV_D_W-1:0]   rem_q;
  logic [DIV_D_W-1:0]   dvs_q;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  assign trial = {rem_q, dq_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      dq_q  <= {dq_q[DIV_N_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

>>> sv/les_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module les_mul import les_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [MUL_A_W-1:0] a_i,
  input  wire logic [MUL_B_W-1:0] b_i,
  output logic                    done_o,
  output logic [MUL_P_W-1:0]      prod_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_A_W-1:0]   hi_q;
  logic [MUL_B_W-1:0]   lo_q;
  logic [MUL_A_W:0]     sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CNT_W'(MUL_B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // multiplier bits leave lo_q as product bits enter from the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[MUL_A_W:1];
      lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule
`default_nettype wire

>>> sv/link_event_anchor_scheduler.sv
// Link event anchor scheduler: sequencer over a serial divider and multiplier.
// Throughput: one request at a time, the next taken the cycle after the result is loaded,
// even while that result still waits on the output.
// Reset (rst_ni low, asynchronous): no link, registers at their defaults, output empty.
`timescale 1ns / 1ps
`default_nettype none
module link_event_anchor_scheduler import les_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // now_us[63:0], time_value_us[127:64], new_chan_map[143:128],
  // new_subrate[151:144], change_instant[167:152]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[2:0], change_kind[3]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // anchor_out_us[63:0], event_counter[79:64], window_half_us[95:80],
  // subrate_out[103:96], chan_map_out[119:104], change_abandoned[120],
  // events_skipped[136:121], zero[143:137]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_OP       = 5'd1;
  localparam logic [4:0] S_HW       = 5'd2;
  localparam logic [4:0] S_HW_MUL   = 5'd3;
  localparam logic [4:0] S_HW_DIV   = 5'd4;
  localparam logic [4:0] S_DISP     = 5'd5;
  localparam logic [4:0] S_EN       = 5'd6;
  localparam logic [4:0] S_EN_DIV   = 5'd7;
  localparam logic [4:0] S_NA       = 5'd8;
  localparam logic [4:0] S_NA_DIV   = 5'd9;
  localparam logic [4:0] S_PLACE    = 5'd10;
  localparam logic [4:0] S_PLACE_MUL = 5'd11;
  localparam logic [4:0] S_GOAL     = 5'd12;
  localparam logic [4:0] S_CMP      = 5'd13;
  localparam logic [4:0] S_TMIN     = 5'd14;
  localparam logic [4:0] S_TMIN_DIV = 5'd15;
  localparam logic [4:0] S_TCMP     = 5'd16;
  localparam logic [4:0] S_M_DIV    = 5'd17;
  localparam logic [4:0] S_M_LAUNCH = 5'd18;
  localparam logic [4:0] S_M_MUL    = 5'd19;
  localparam logic [4:0] S_PEND     = 5'd20;
  localparam logic [4:0] S_OUT      = 5'd21;

  // what the event-number walk is doing
  localparam logic [1:0] PH_CU1 = 2'd0;  // align to an active event
  localparam logic [1:0] PH_CU2 = 2'd1;  // jump past the goal
  localparam logic [1:0] PH_FIN = 2'd2;  // final placement
  localparam logic [1:0] PH_ADV = 2'd3;  // advance by one active event

  logic [4:0] state_q, state_d;
  logic [1:0] phase_q;
  logic       docatch_q, doadv_q;

  // configuration
  logic        init_q;
  logic [21:0] intv_q;
  logic [9:0]  ppm_q;
  logic [13:0] wmin_q;
  logic [16:0] wmax_q;
  logic [16:0] lead_q;

  // link state
  logic              link_q;
  logic [TIME_W-1:0] anchor_q, epoch_q, lsync_q;
  logic [15:0]       cnt_q, map_q, pmap_q, pinst_q;
  logic [7:0]        sub_q, prate_q;
  logic [1:0]        pflags_q;
  logic              conf_q;

  // request and working registers
  logic [2:0]        op_q;
  logic              kind_q;
  logic [TIME_W-1:0] now_q, tv_q;
  logic [15:0]       nmap_q, ninst_q;
  logic [7:0]        nsub_q;
  logic [15:0]       hw_q;
  logic [TIME_W-1:0] k_q, t_q, goal_q, tmin_q;
  logic [15:0]       skip_q;
  logic              drop_q;
  logic              ovalid_q;
  logic [OUT_DATA_W-1:0] odata_q;

  // arithmetic units
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_N_W-1:0] div_quot;
  logic [DIV_D_W-1:0] div_rem;

  les_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  les_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  logic [7:0]        step;
  logic [TIME_W-1:0] elapsed;
  logic              intv_zero, en_zero, rem_nz, en_round, do_out;
  logic [15:0]       lim, hw_calc;
  logic [16:0]       cwin, hw_sum;
  logic [TIME_W-1:0] drift, next_act, goal_calc, soon, goal_dist, m_calc, q64;
  logic [17:0]       goal_off;
  logic [TIME_W:0]   goal_sum, soon_sum;
  logic [DIV_D_W:0]  round_sum;
  logic [15:0]       skip_calc;

  assign step      = (sub_q == 8'd0) ? 8'd1 : sub_q;
  assign elapsed   = (lsync_q != '0 && now_q > lsync_q) ? now_q - lsync_q : '0;
  assign intv_zero = intv_q == '0;
  assign en_zero   = intv_zero || (anchor_q < epoch_q);
  assign q64       = div_quot[TIME_W-1:0];
  assign rem_nz    = div_rem != '0;
  assign round_sum = {1'b0, div_rem} + {2'b0, intv_q[21:1]};
  assign en_round  = round_sum >= {1'b0, intv_q};
  // k - k mod s + s, which is the next multiple of s above k
  assign next_act  = k_q - {56'b0, div_rem[7:0]} + {56'b0, step};

  assign lim     = wmax_q[16:1];
  assign cwin    = JITTER_US + {4'b0, wmin_q[13:1]};
  assign drift   = q64;
  assign hw_sum  = {1'b0, drift[15:0]} + cwin;
  assign hw_calc = (drift >= {48'b0, lim}) ? lim :
                   ((hw_sum < {1'b0, lim}) ? hw_sum[15:0] : lim);

  assign goal_off  = {1'b0, lead_q} + {2'b0, hw_q} + CATCHUP_MARGIN_US;
  assign goal_sum  = {1'b0, now_q} + {47'b0, goal_off};
  assign goal_calc = goal_sum[TIME_W] ? '1 : goal_sum[TIME_W-1:0];
  assign soon_sum  = {1'b0, now_q} + EXPEDITE_LEAD_US;
  assign soon      = soon_sum[TIME_W] ? '1 : soon_sum[TIME_W-1:0];
  assign goal_dist = (goal_q > epoch_q) ? goal_q - epoch_q : '0;
  assign m_calc    = q64 + {63'b0, rem_nz};
  assign skip_calc = (k_q >= 64'd65534) ? 16'hFFFF : k_q[15:0] + 16'd1;
  assign do_out    = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);

  // sequencer and unit launches
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_OP;
      S_OP:   state_d = S_HW;
      S_HW: begin
        if (init_q) begin
          state_d = S_DISP;
        end else begin
          mul_start = 1'b1;
          mul_a     = elapsed;
          mul_b     = {12'b0, ppm_q};
          state_d   = S_HW_MUL;
        end
      end
      S_HW_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_prod[DIV_N_W-1:0];
          div_d     = PPM_SCALE;
          state_d   = S_HW_DIV;
        end
      end
      S_HW_DIV: if (div_done) state_d = S_DISP;
      S_DISP: begin
        if (docatch_q) state_d = intv_zero ? S_OUT : S_EN;
        else if (doadv_q) state_d = S_EN;
        else state_d = S_OUT;
      end
      S_EN: begin
        if (en_zero) begin
          state_d = S_NA;
        end else begin
          div_start = 1'b1;
          div_n     = {10'b0, anchor_q - epoch_q};
          div_d     = intv_q;
          state_d   = S_EN_DIV;
        end
      end
      S_EN_DIV: if (div_done) state_d = S_NA;
      S_NA: begin
        div_start = 1'b1;
        div_n     = {10'b0, k_q};
        div_d     = {14'b0, step};
        state_d   = S_NA_DIV;
      end
      S_NA_DIV: begin
        if (div_done) begin
          case (phase_q)
            PH_CU1:  state_d = rem_nz ? S_PLACE : S_GOAL;
            PH_CU2:  state_d = S_TMIN;
            default: state_d = S_PLACE;
          endcase
        end
      end
      S_PLACE: begin
        mul_start = 1'b1;
        mul_a     = t_q;
        mul_b     = intv_q;
        state_d   = S_PLACE_MUL;
      end
      S_PLACE_MUL: begin
        if (mul_done) begin
          case (phase_q)
            PH_CU1:  state_d = S_GOAL;
            PH_ADV:  state_d = S_PEND;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_GOAL: state_d = S_CMP;
      S_CMP:  state_d = (anchor_q >= goal_q) ? S_OUT : S_EN;
      S_TMIN: begin
        div_start = 1'b1;
        div_n     = {10'b0, goal_dist};
        div_d     = intv_q;
        state_d   = S_TMIN_DIV;
      end
      S_TMIN_DIV: if (div_done) state_d = S_TCMP;
      S_TCMP: begin
        if (t_q < tmin_q) begin
          div_start = 1'b1;
          div_n     = {10'b0, tmin_q - t_q};
          div_d     = {14'b0, step};
          state_d   = S_M_DIV;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_M_DIV: if (div_done) state_d = S_M_LAUNCH;
      S_M_LAUNCH: begin
        mul_start = 1'b1;
        mul_a     = k_q;
        mul_b     = {14'b0, step};
        state_d   = S_M_MUL;
      end
      S_M_MUL: if (mul_done) state_d = S_PLACE;
      S_PEND:  state_d = S_OUT;
      S_OUT:   if (do_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control, configuration and link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_CU1;
      docatch_q <= 1'b0;
      doadv_q   <= 1'b0;
      ovalid_q  <= 1'b0;
      skip_q    <= '0;
      drop_q    <= 1'b0;
      init_q    <= 1'b0;
      intv_q    <= 22'd100000;
      ppm_q     <= 10'd100;
      wmin_q    <= 14'd200;
      wmax_q    <= 17'd4000;
      lead_q    <= 17'd1000;
      link_q    <= 1'b0;
      anchor_q  <= '0;
      epoch_q   <= '0;
      lsync_q   <= '0;
      cnt_q     <= '0;
      map_q     <= '0;
      pmap_q    <= '0;
      pinst_q   <= '0;
      sub_q     <= 8'd1;
      prate_q   <= '0;
      pflags_q  <= '0;
      conf_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_IS_INIT:  init_q <= cfg_data_i[0];
          CFG_INTERVAL: intv_q <= cfg_data_i;
          CFG_PPM:      ppm_q  <= cfg_data_i[9:0];
          CFG_WIN_MIN:  wmin_q <= cfg_data_i[13:0];
          CFG_WIN_MAX:  wmax_q <= cfg_data_i[16:0];
          CFG_LEAD:     lead_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end

      if (do_out) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;

      unique case (state_q)
        S_OP: begin
          skip_q    <= '0;
          drop_q    <= 1'b0;
          docatch_q <= 1'b0;
          doadv_q   <= 1'b0;
          case (op_q)
            OP_ESTABLISH: begin
              anchor_q  <= tv_q;
              epoch_q   <= tv_q;
              cnt_q     <= '0;
              map_q     <= nmap_q;
              sub_q     <= 8'd1;
              pflags_q  <= '0;
              conf_q    <= 1'b0;
              lsync_q   <= now_q;
              link_q    <= 1'b1;
              docatch_q <= 1'b1;
            end
            OP_QUERY:   docatch_q <= link_q;
            OP_ADVANCE: doadv_q <= link_q;
            OP_RESYNC: begin
              if (link_q && !init_q) begin
                epoch_q  <= epoch_q + tv_q - anchor_q;
                anchor_q <= tv_q;
                lsync_q  <= now_q;
              end
            end
            OP_POST: begin
              if (kind_q) begin
                prate_q     <= nsub_q;
                pflags_q[1] <= 1'b1;
              end else begin
                pmap_q      <= nmap_q;
                pflags_q[0] <= 1'b1;
              end
              pinst_q <= ninst_q;
              conf_q  <= 1'b0;
            end
            OP_ACK: if (pflags_q != '0) conf_q <= 1'b1;
            OP_EXPEDITE: begin
              if (link_q && init_q && anchor_q > soon) begin
                anchor_q <= soon;
                sub_q    <= 8'd1;
              end
            end
            default: ;
          endcase
        end
        S_DISP: phase_q <= docatch_q ? PH_CU1 : PH_ADV;
        S_PLACE_MUL: begin
          if (mul_done) begin
            anchor_q <= epoch_q + mul_prod[TIME_W-1:0];
            cnt_q    <= t_q[15:0];
          end
        end
        S_CMP:      if (anchor_q < goal_q) phase_q <= PH_CU2;
        S_TMIN_DIV: if (div_done) skip_q <= 16'd1;
        S_TCMP:     if (t_q >= tmin_q) phase_q <= PH_FIN;
        S_M_LAUNCH: begin
          skip_q  <= skip_calc;
          phase_q <= PH_FIN;
        end
        S_PEND: begin
          // change instant compared without wrap handling
          if (pflags_q != '0 && cnt_q >= pinst_q) begin
            if (!init_q || conf_q) begin
              if (pflags_q[0]) map_q <= pmap_q;
              if (pflags_q[1]) sub_q <= (prate_q == 8'd0) ? 8'd1 : prate_q;
            end else begin
              drop_q <= 1'b1;
            end
            pflags_q <= '0;
            conf_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture and working values
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_q    <= s_axis_tuser[2:0];
          kind_q  <= s_axis_tuser[3];
          now_q   <= s_axis_tdata[63:0];
          tv_q    <= s_axis_tdata[127:64];
          nmap_q  <= s_axis_tdata[143:128];
          nsub_q  <= s_axis_tdata[151:144];
          ninst_q <= s_axis_tdata[167:152];
        end
      end
      S_HW:       if (init_q) hw_q <= {3'b0, wmin_q[13:1]};
      S_HW_DIV:   if (div_done) hw_q <= hw_calc;
      S_EN:       if (en_zero) k_q <= '0;
      S_EN_DIV:   if (div_done) k_q <= q64 + {63'b0, en_round};
      S_NA_DIV:   if (div_done) t_q <= next_act;
      S_GOAL:     goal_q <= goal_calc;
      S_TMIN_DIV: if (div_done) tmin_q <= m_calc;
      S_M_DIV:    if (div_done) k_q <= m_calc;
      S_M_MUL:    if (mul_done) t_q <= t_q + mul_prod[TIME_W-1:0];
      S_OUT: begin
        if (do_out) begin
          odata_q <= {7'b0, skip_q, drop_q, map_q, sub_q, hw_q, cnt_q,
                      (link_q && !intv_zero) ? anchor_q : {TIME_W{1'b1}}};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  a_sub_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 8'd0)
    else $error("subrate in force is zero");

  a_div_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_HW_DIV || state_q == S_EN_DIV || state_q == S_NA_DIV ||
                  state_q == S_TMIN_DIV || state_q == S_M_DIV))
    else $error("divider finished outside a wait state");

  a_mul_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_HW_MUL || state_q == S_PLACE_MUL || state_q == S_M_MUL))
    else $error("multiplier finished outside a wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output state");

endmodule
`default_nettype wire
